@@ hw/rtl/rmsn_pkg.sv @@
`default_nettype none

package rmsn_pkg;

  // Sizing of the gain table and gain format
  localparam int MAX_LENGTH = 8192;
  localparam int GAIN_BITS  = 16;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int GAIN_FRAC  = GAIN_BITS - 2;

  // Field and state widths
  localparam int ACTION_W = 2;
  localparam int POS_W    = 13;
  localparam int GAIN_W   = 16;
  localparam int ELEM_W   = 24;
  localparam int LEN_W    = 14;
  localparam int EPS_W    = 32;
  localparam int INV_W    = 32;
  localparam int SUM_W    = 64;

  // Shared multiplier operand widths (gain magnitude fits MUL_B_W for GAIN_BITS <= 24)
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 24;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_GAIN  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ACCUM = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_NORM  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 1'b1;

  localparam logic [LEN_W-1:0] LENGTH_RESET  = 14'd128;
  localparam logic [EPS_W-1:0] EPSILON_RESET = 32'd4295;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic [POS_W-1:0]         position;
    logic signed [GAIN_W-1:0] gain_value;
    logic signed [ELEM_W-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] normalized_value;
    logic                     not_ready;
    logic                     saturated;
  } result_t;

  // Rescale an incoming Q2.14 gain to Q2.(GAIN_BITS-2), flooring when narrowing
  function automatic logic [GAIN_BITS-1:0] store_gain(input logic signed [GAIN_W-1:0] g);
    logic signed [39:0] wide;
    wide = 40'(g) <<< 24;
    wide = wide >>> (40 - GAIN_BITS);
    return wide[GAIN_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rms_normalizer.sv @@
// Gain write: the sequencer stays idle, so item_ready stays high.
// Accumulate: square and add; the closing beat of a vector adds 64 divide steps by the length,
//   1 epsilon add and, if v > 2^16, 81 steps of 2^80 / v and 32 root steps on one subtractor.
// Normalize: S_N_MUL1, S_N_RND, S_N_MUL2 (the shared multiplier used twice per element), then
//   S_N_OUT registers the result (alone before any scale); a stalled result holds the sequencer.
// Reset (rst, synchronous): registers to defaults, sum, count and scale cleared; gain table kept.
`default_nettype none

module rms_normalizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  rmsn_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output rmsn_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rmsn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmsn_pkg::EPS_W-1:0]          cfg_data
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ_MUL  = 4'd1;
  localparam logic [3:0] S_SQ_ADD  = 4'd2;
  localparam logic [3:0] S_DIV_SUM = 4'd3;
  localparam logic [3:0] S_ADD_EPS = 4'd4;
  localparam logic [3:0] S_DIV_INV = 4'd5;
  localparam logic [3:0] S_SQRT    = 4'd6;
  localparam logic [3:0] S_N_MUL1  = 4'd7;
  localparam logic [3:0] S_N_RND   = 4'd8;
  localparam logic [3:0] S_N_MUL2  = 4'd9;
  localparam logic [3:0] S_N_OUT   = 4'd10;

  localparam int STEP_W        = 7;
  localparam int DIV_SUM_STEPS = 64;
  localparam int DIV_INV_STEPS = 81;
  localparam int SQRT_STEPS    = 32;
  localparam int REM_W         = 65;

  localparam logic [rmsn_pkg::SUM_W-1:0] V_SAT_LIMIT = 64'h1_0000;
  localparam logic [rmsn_pkg::PROD_W-1:0] RND1 = rmsn_pkg::PROD_W'(1) << 23;
  localparam logic [rmsn_pkg::PROD_W-1:0] RND2 =
    rmsn_pkg::PROD_W'(1) << (rmsn_pkg::GAIN_FRAC - 1);
  localparam logic [rmsn_pkg::PROD_W-1:0] POS_MAX = rmsn_pkg::PROD_W'(24'h7F_FFFF);
  localparam logic [rmsn_pkg::PROD_W-1:0] NEG_MAX = rmsn_pkg::PROD_W'(24'h80_0000);

  // Control and configuration state
  logic [3:0]                         state;
  logic [rmsn_pkg::LEN_W-1:0]         vector_length;
  logic [rmsn_pkg::EPS_W-1:0]         epsilon;
  logic [rmsn_pkg::SUM_W-1:0]         square_sum;
  logic [rmsn_pkg::LEN_W-1:0]         element_count;
  logic [rmsn_pkg::INV_W-1:0]         inverse_rms;
  logic                               scale_ready;
  logic [STEP_W-1:0]                  step;

  // Datapath registers
  logic [rmsn_pkg::ELEM_W-1:0]        em;
  logic                               e_neg;
  logic                               gain_zero;
  logic                               neg;
  logic [rmsn_pkg::PROD_W-1:0]        prod;
  logic [rmsn_pkg::MUL_A_W-1:0]       m1;
  logic [REM_W-1:0]                   rem;
  logic [REM_W-1:0]                   den;
  logic [rmsn_pkg::SUM_W-1:0]         q;
  logic [rmsn_pkg::INV_W-1:0]         root;
  logic [rmsn_pkg::GAIN_BITS-1:0]     gain_rd;

  // Gain table
  logic [rmsn_pkg::GAIN_BITS-1:0]     gain_mem [rmsn_pkg::MAX_LENGTH];

  logic                               accept;
  logic                               pos_ok;
  logic [rmsn_pkg::ADDR_W-1:0]        gain_addr;
  logic [rmsn_pkg::ELEM_W-1:0]        e_mag;
  logic [rmsn_pkg::LEN_W-1:0]         len_eff;
  logic [rmsn_pkg::LEN_W-1:0]         count_inc;
  logic [rmsn_pkg::SUM_W-1:0]         sum_add;
  logic [rmsn_pkg::SUM_W-1:0]         v_sum;
  logic                               g_neg;
  logic [rmsn_pkg::GAIN_BITS-1:0]     g_mag;
  logic [rmsn_pkg::MUL_A_W-1:0]       mul_a;
  logic [rmsn_pkg::MUL_B_W-1:0]       mul_b;
  logic [rmsn_pkg::PROD_W-1:0]        mul_p;
  logic [REM_W-1:0]                   sub_a;
  logic [REM_W-1:0]                   sub_b;
  logic [REM_W:0]                     sub_diff;
  logic                               sub_ge;
  logic [REM_W-1:0]                   sub_keep;
  logic [rmsn_pkg::PROD_W-1:0]        m2;
  rmsn_pkg::result_t                  res_next;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;

  // Decode the incoming beat
  assign pos_ok    = 32'(item.position) < 32'(rmsn_pkg::MAX_LENGTH);
  assign gain_addr = rmsn_pkg::ADDR_W'(item.position);
  assign e_mag     = item.element_value[rmsn_pkg::ELEM_W-1] ?
                     rmsn_pkg::ELEM_W'(-item.element_value) :
                     rmsn_pkg::ELEM_W'(item.element_value);

  assign len_eff   = (vector_length == '0) ? rmsn_pkg::LEN_W'(1) : vector_length;
  assign count_inc = element_count + rmsn_pkg::LEN_W'(1);
  assign sum_add   = square_sum + rmsn_pkg::SUM_W'(prod);
  assign v_sum     = q + rmsn_pkg::SUM_W'(epsilon);

  // Gain magnitude and sign; an out-of-range position acts as gain zero
  assign g_neg = gain_rd[rmsn_pkg::GAIN_BITS-1] && !gain_zero;
  assign g_mag = gain_zero ? '0 : (g_neg ? -gain_rd : gain_rd);

  // Shared multiplier operand select
  always_comb begin
    case (state)
      S_SQ_MUL: begin
        mul_a = rmsn_pkg::MUL_A_W'(em);
        mul_b = em;
      end
      S_N_MUL1: begin
        mul_a = inverse_rms;
        mul_b = em;
      end
      default: begin
        mul_a = m1;
        mul_b = rmsn_pkg::MUL_B_W'(g_mag);
      end
    endcase
  end

  assign mul_p = rmsn_pkg::PROD_W'(mul_a) * rmsn_pkg::PROD_W'(mul_b);

  // Shared compare-and-subtract unit for both divides and the square root
  always_comb begin
    case (state)
      S_DIV_SUM: begin
        sub_a = {rem[REM_W-2:0], q[rmsn_pkg::SUM_W-1]};
        sub_b = den;
      end
      S_DIV_INV: begin
        sub_a = {rem[REM_W-2:0], (step == '0)};
        sub_b = den;
      end
      S_SQRT: begin
        sub_a = {rem[REM_W-3:0], q[rmsn_pkg::SUM_W-1 -: 2]};
        sub_b = REM_W'({root, 2'b01});
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[REM_W];
  assign sub_keep = sub_ge ? sub_diff[REM_W-1:0] : sub_a;

  // Round the second product and clip to Q8.16
  assign m2 = (prod + RND2) >> rmsn_pkg::GAIN_FRAC;

  always_comb begin
    res_next = '0;
    if (!scale_ready) begin
      res_next.not_ready = 1'b1;
    end else if (neg) begin
      res_next.saturated = m2 > NEG_MAX;
      res_next.normalized_value = res_next.saturated ? 24'sh80_0000 :
                                  rmsn_pkg::ELEM_W'(24'd0 - m2[rmsn_pkg::ELEM_W-1:0]);
    end else begin
      res_next.saturated = m2 > POS_MAX;
      res_next.normalized_value = res_next.saturated ? 24'sh7F_FFFF :
                                  m2[rmsn_pkg::ELEM_W-1:0];
    end
  end

  // Gain table write and registered read
  always_ff @(posedge clk) begin
    if (accept && item.action == rmsn_pkg::ACT_GAIN && pos_ok) begin
      gain_mem[gain_addr] <= rmsn_pkg::store_gain(item.gain_value);
    end
    if (accept) begin
      gain_rd <= gain_mem[gain_addr];
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= rmsn_pkg::LENGTH_RESET;
      epsilon       <= rmsn_pkg::EPSILON_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rmsn_pkg::CFG_VECTOR_LENGTH: vector_length <= cfg_data[rmsn_pkg::LEN_W-1:0];
        rmsn_pkg::CFG_EPSILON:       epsilon       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      square_sum    <= '0;
      element_count <= '0;
      inverse_rms   <= '0;
      scale_ready   <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            em        <= e_mag;
            e_neg     <= item.element_value[rmsn_pkg::ELEM_W-1];
            gain_zero <= !pos_ok;
            case (item.action)
              rmsn_pkg::ACT_ACCUM: state <= S_SQ_MUL;
              rmsn_pkg::ACT_NORM:  state <= scale_ready ? S_N_MUL1 : S_N_OUT;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_SQ_MUL: begin
          prod  <= mul_p;
          state <= S_SQ_ADD;
        end
        S_SQ_ADD: begin
          if (count_inc >= len_eff) begin
            // close the vector and start the divide by the length
            q             <= sum_add;
            rem           <= '0;
            den           <= REM_W'(len_eff);
            step          <= '0;
            square_sum    <= '0;
            element_count <= '0;
            state         <= S_DIV_SUM;
          end else begin
            square_sum    <= sum_add;
            element_count <= count_inc;
            state         <= S_IDLE;
          end
        end
        S_DIV_SUM: begin
          rem  <= sub_keep;
          q    <= {q[rmsn_pkg::SUM_W-2:0], sub_ge};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_SUM_STEPS - 1)) begin
            state <= S_ADD_EPS;
          end
        end
        S_ADD_EPS: begin
          den <= REM_W'(v_sum);
          if (v_sum <= V_SAT_LIMIT) begin
            inverse_rms <= '1;
            scale_ready <= 1'b1;
            state       <= S_IDLE;
          end else begin
            rem   <= '0;
            q     <= '0;
            step  <= '0;
            state <= S_DIV_INV;
          end
        end
        S_DIV_INV: begin
          rem  <= sub_keep;
          q    <= {q[rmsn_pkg::SUM_W-2:0], sub_ge};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_INV_STEPS - 1)) begin
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rem  <= sub_keep;
          root <= {root[rmsn_pkg::INV_W-2:0], sub_ge};
          q    <= q << 2;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            inverse_rms <= {root[rmsn_pkg::INV_W-2:0], sub_ge};
            scale_ready <= 1'b1;
            state       <= S_IDLE;
          end
        end
        S_N_MUL1: begin
          prod  <= mul_p;
          state <= S_N_RND;
        end
        S_N_RND: begin
          m1    <= rmsn_pkg::MUL_A_W'((prod + RND1) >> 24);
          state <= S_N_MUL2;
        end
        S_N_MUL2: begin
          prod  <= mul_p;
          neg   <= e_neg ^ g_neg;
          state <= S_N_OUT;
        end
        S_N_OUT: begin
          // hold until the output register is free
          if (!result_valid || result_ready) begin
            result       <= res_next;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rmsn_checker.sv @@
`default_nettype none

module rmsn_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  input  logic                           item_ready,
  input  rmsn_pkg::item_t                item,
  input  logic                           result_valid,
  input  logic                           result_ready,
  input  rmsn_pkg::result_t              result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rmsn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmsn_pkg::EPS_W-1:0]     cfg_data
);

  // Stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat dropped or changed while stalled");

  // Normalize beat occupies the sequencer
  a_norm_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.action == rmsn_pkg::ACT_NORM |=> !item_ready)
    else $error("ready stayed high after a normalize beat");

  // Gain write leaves the input ready
  a_gain_quick: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.action == rmsn_pkg::ACT_GAIN |=> item_ready)
    else $error("gain write stalled the input");

  // No-scale result carries zero and no clip flag
  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.not_ready |-> result.normalized_value == '0 && !result.saturated)
    else $error("not_ready result with nonzero payload");

  // Clipped result sits at a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      result.normalized_value == 24'sh7F_FFFF || result.normalized_value == 24'sh80_0000)
    else $error("saturated result off the rails");

endmodule

bind rms_normalizer rmsn_checker u_rmsn_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .item         (item),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rmsn_pkg::*;

  // Unused action code, which the block drops
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // Cycles to let a vector-closing accumulate finish before a register write
  localparam int SETTLE_CYCLES = 300;
  localparam int TIMEOUT_NS    = 20_000_000;

  logic    clk;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [EPS_W-1:0]     cfg_data = '0;

  // Idle percentages of the sender and the receiver
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  // Shadow state of the normalizer
  logic signed [GAIN_BITS-1:0] gain_mem [MAX_LENGTH];
  bit                          gain_written [MAX_LENGTH];
  int unsigned                 written_pos [$];
  logic [SUM_W-1:0]            sum_sq = '0;
  logic [LEN_W-1:0]            count_acc = '0;
  logic [INV_W-1:0]            inv_rms = '0;
  bit                          have_scale = 1'b0;
  logic [LEN_W-1:0]            cur_len = LENGTH_RESET;
  logic [EPS_W-1:0]            cur_eps = EPSILON_RESET;

  result_t     expected_norm [$];
  result_t     want;
  int unsigned mismatch_count = 0;

  rms_normalizer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rescale a Q2.14 gain to the table format, flooring when narrowing
  function automatic logic signed [GAIN_BITS-1:0] gain_entry(input logic signed [GAIN_W-1:0] g);
    longint w;
    w = longint'(g);
    if (GAIN_BITS < GAIN_W) w = w >>> (GAIN_W - GAIN_BITS);
    else w = w <<< (GAIN_BITS - GAIN_W);
    return w[GAIN_BITS-1:0];
  endfunction

  // floor(2^40 / sqrt(v)), pinned to all ones for small v
  function automatic logic [INV_W-1:0] inverse_root(input logic [SUM_W-1:0] v);
    logic [127:0] q;
    logic [63:0]  root;
    logic [63:0]  trial;
    int           b;
    if (v <= 64'd65536) return '1;
    q = (128'd1 << 80) / {64'd0, v};
    root = '0;
    for (b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= q[63:0]) root = trial;
    end
    return root[INV_W-1:0];
  endfunction

  // Advance the shadow state by one item; return 1 with the normalized beat if one is due
  function automatic bit predict_item(input item_t it, output result_t r);
    longint                      sv_e;
    longint                      sv_g;
    longint unsigned             em;
    longint unsigned             gm;
    longint unsigned             m1;
    longint unsigned             m2;
    longint unsigned             len;
    logic [SUM_W-1:0]            v;
    logic signed [GAIN_BITS-1:0] g;
    bit                          neg;
    r = '0;
    sv_e = longint'($signed(it.element_value));
    em = (sv_e < 0) ? longint'(-sv_e) : longint'(sv_e);
    case (it.action)
      ACT_GAIN: begin
        if (it.position < MAX_LENGTH) begin
          gain_mem[it.position] = gain_entry(it.gain_value);
          if (!gain_written[it.position]) begin
            gain_written[it.position] = 1'b1;
            written_pos.push_back(it.position);
          end
        end
        return 1'b0;
      end
      ACT_ACCUM: begin
        len = (cur_len == 0) ? 1 : cur_len;
        sum_sq = sum_sq + em * em;
        count_acc = count_acc + 1'b1;
        if (count_acc >= len) begin
          v = sum_sq / len + cur_eps;
          inv_rms = inverse_root(v);
          have_scale = 1'b1;
          sum_sq = '0;
          count_acc = '0;
        end
        return 1'b0;
      end
      ACT_NORM: begin
        if (!have_scale) begin
          r.not_ready = 1'b1;
          return 1'b1;
        end
        g = (it.position < MAX_LENGTH) ? gain_mem[it.position] : '0;
        sv_g = longint'(g);
        gm = (sv_g < 0) ? longint'(-sv_g) : longint'(sv_g);
        neg = (sv_e < 0) != (sv_g < 0);
        m1 = (em * inv_rms + (64'd1 << 23)) >> 24;
        m2 = (m1 * gm + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
        if (neg) begin
          if (m2 > 64'h800000) begin
            m2 = 64'h800000;
            r.saturated = 1'b1;
          end
          r.normalized_value = ELEM_W'(64'd0 - m2);
        end else begin
          if (m2 > 64'h7FFFFF) begin
            m2 = 64'h7FFFFF;
            r.saturated = 1'b1;
          end
          r.normalized_value = ELEM_W'(m2);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic item_t make_item(input logic [ACTION_W-1:0] act, input logic [31:0] pos,
                                      input logic [31:0] gain, input logic [31:0] elem);
    item_t it;
    it.action        = act;
    it.position      = pos[POS_W-1:0];
    it.gain_value    = gain[GAIN_W-1:0];
    it.element_value = elem[ELEM_W-1:0];
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h4000;
      3: return 16'hC000;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] rand_element();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3, 4: return ELEM_W'(int'($urandom_range(511)) - 256);
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic void note_failure(input string what, input result_t exp_r,
                                       input result_t got_r);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: expected value=%0d not_ready=%0b saturated=%0b, got value=%0d not_ready=%0b saturated=%0b",
               $time, what, exp_r.normalized_value, exp_r.not_ready, exp_r.saturated,
               got_r.normalized_value, got_r.not_ready, got_r.saturated);
  endfunction

  // Send one beat, idling first at random; valid stays high for the next beat
  task automatic send_item(input item_t it);
    result_t r;
    while ($urandom_range(99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    if (predict_item(it, r)) expected_norm.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EPS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_VECTOR_LENGTH) cur_len = data[LEN_W-1:0];
    else if (idx == CFG_EPSILON) cur_eps = data;
  endtask

  // Drain outstanding results, let any closing divide finish, then write both registers
  task automatic configure(input logic [LEN_W-1:0] len, input logic [EPS_W-1:0] eps);
    item_valid <= 1'b0;
    while (expected_norm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_VECTOR_LENGTH, EPS_W'(len));
    write_reg(CFG_EPSILON, eps);
    cfg_valid <= 1'b0;
  endtask

  // Normalize before any scale exists, plus a dropped beat
  task automatic test_not_ready();
    send_item(make_item(ACT_GAIN, 0, 16'h7FFF, 24'h123456));
    send_item(make_item(ACT_GAIN, MAX_LENGTH - 1, 16'h8000, 24'hFFFFFF));
    send_item(make_item(ACT_GAIN, MAX_LENGTH / 2, 16'h4000, 24'h000000));
    send_item(make_item(ACT_NORM, 0, 16'h0000, 24'h7FFFFF));
    send_item(make_item(ACT_NORM, MAX_LENGTH - 1, 16'hFFFF, 24'h800000));
    send_item(make_item(ACT_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
  endtask

  // Zero length acts as one; zero mean square pins the scale and makes full-scale elements clip
  task automatic test_zero_length();
    configure(14'd0, 32'd0);
    send_item(make_item(ACT_ACCUM, 0, 0, 24'h000000));
    send_item(make_item(ACT_NORM, 0, 0, 24'h7FFFFF));
    send_item(make_item(ACT_NORM, MAX_LENGTH - 1, 0, 24'h7FFFFF));
    send_item(make_item(ACT_NORM, MAX_LENGTH - 1, 0, 24'h800000));
    send_item(make_item(ACT_NORM, MAX_LENGTH / 2, 0, 24'h000000));
    send_item(make_item(ACT_NORM, MAX_LENGTH / 2, 0, 24'h000001));
  endtask

  // Shrink the length mid-vector so the next accumulate closes at once
  task automatic test_length_change();
    configure(14'd4, 32'hFFFFFFFF);
    send_item(make_item(ACT_ACCUM, 0, 0, 24'h800000));
    send_item(make_item(ACT_ACCUM, 0, 0, 24'h7FFFFF));
    send_item(make_item(ACT_ACCUM, 0, 0, 24'h000000));
    configure(14'd2, 32'hFFFFFFFF);
    send_item(make_item(ACT_ACCUM, 0, 0, 24'h012345));
    send_item(make_item(ACT_NORM, 0, 0, 24'h800000));
    send_item(make_item(ACT_NORM, MAX_LENGTH / 2, 0, 24'h7FFFFF));
  endtask

  // Normalize with the previous scale while the next vector is open
  task automatic test_scale_reuse();
    send_item(make_item(ACT_ACCUM, 0, 0, 24'h123456));
    send_item(make_item(ACT_NORM, MAX_LENGTH / 2, 0, 24'h0ABCDE));
    send_item(make_item(ACT_ACCUM, 0, 0, 24'hF00000));
    send_item(make_item(ACT_NORM, MAX_LENGTH / 2, 0, 24'h0ABCDE));
  endtask

  // Longest vector with full-scale elements: near the largest square sum
  task automatic test_full_length();
    int unsigned k;
    configure(14'(MAX_LENGTH), EPSILON_RESET);
    k = 0;
    do begin
      send_item(make_item(ACT_ACCUM, $urandom, $urandom, k[0] ? 24'h800000 : 24'h7FFFFF));
      k++;
    end while (count_acc != 0);
    send_item(make_item(ACT_NORM, 0, 0, 24'h7FFFFF));
    send_item(make_item(ACT_NORM, MAX_LENGTH - 1, 0, 24'h7FFFFF));
    send_item(make_item(ACT_NORM, MAX_LENGTH / 2, 0, 24'h800000));
  endtask

  // Random vectors, some cut short: optional reconfigure, gains, accumulate, normalize, noise
  task automatic test_random_vectors(input int unsigned n_items);
    int unsigned              sent;
    int unsigned              len;
    int unsigned              base;
    int unsigned              i;
    logic [LEN_W-1:0]         new_len;
    logic [EPS_W-1:0]         new_eps;
    logic [ELEM_W-1:0]        e;
    logic [ELEM_W-1:0]        vec [$];
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0: new_len = '0;
          1: new_len = 14'd1;
          2: new_len = LEN_W'($urandom_range(200, 17));
          default: new_len = LEN_W'($urandom_range(16, 2));
        endcase
        case ($urandom_range(5))
          0: new_eps = '0;
          1: new_eps = '1;
          2: new_eps = EPSILON_RESET;
          3: new_eps = $urandom_range(65536);
          default: new_eps = $urandom;
        endcase
        configure(new_len, new_eps);
      end
      len  = (cur_len == 0) ? 1 : cur_len;
      base = $urandom_range(MAX_LENGTH - len);

      // Load the gains for this vector
      for (i = 0; i < len; i++) begin
        send_item(make_item(ACT_GAIN, base + i, rand_gain(), $urandom));
        sent++;
      end

      // Accumulate until the vector closes, now and then abandon it early
      vec.delete();
      do begin
        e = rand_element();
        vec.push_back(e);
        send_item(make_item(ACT_ACCUM, $urandom, $urandom, e));
        sent++;
        if ($urandom_range(15) == 0) break;
      end while (count_acc != 0);

      // Normalize pass, with noise mixed in
      for (i = 0; i < vec.size(); i++) begin
        if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0: send_item(make_item(ACT_UNUSED, $urandom, $urandom, $urandom));
            1: begin
              send_item(make_item(ACT_GAIN, $urandom, rand_gain(), $urandom));
              sent++;
            end
            2: begin
              send_item(make_item(ACT_NORM, written_pos[$urandom_range(written_pos.size() - 1)],
                                  $urandom, rand_element()));
              sent++;
            end
            default: begin
              send_item(make_item(ACT_ACCUM, $urandom, $urandom, rand_element()));
              sent++;
            end
          endcase
        end
        e = ($urandom_range(3) == 0) ? rand_element() : vec[i];
        send_item(make_item(ACT_NORM, base + i, $urandom, e));
        sent++;
      end
    end
  endtask

  // Throttle the result side
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Compare each returned beat with the oldest expected one
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_norm.size() == 0) begin
        note_failure("unexpected result", '0, result);
      end else begin
        want = expected_norm.pop_front();
        if (result.normalized_value !== want.normalized_value ||
            result.not_ready !== want.not_ready ||
            result.saturated !== want.saturated) begin
          note_failure("result mismatch", want, result);
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_idle = 20;
    recv_idle = 79;
    test_not_ready();
    test_zero_length();
    test_length_change();
    test_scale_reuse();
    test_random_vectors(380);

    send_idle = 79;
    recv_idle = 20;
    test_random_vectors(380);

    send_idle = 0;
    recv_idle = 0;
    test_full_length();
    test_random_vectors(390);

    // Drain and let the pipeline settle
    item_valid <= 1'b0;
    while (expected_norm.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
